// ----- rtl/crtr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package crtr_pkg;

  localparam int WORD_BITS = 60;

  // bits of the multiplier operand consumed per pipeline stage
  localparam int MM_STEP = 2;
  localparam int MM_STAGES = (WORD_BITS + MM_STEP - 1) / MM_STEP;
  localparam int MM_PAD = MM_STAGES * MM_STEP;

  // eight chained modular units plus three add/subtract register stages
  localparam int PIPE_DEPTH = 8 * MM_STAGES + 3;

  localparam int CFG_IDX_BITS = 3;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_NUM_PRIMES = cfg_idx_t'(0);
  localparam cfg_idx_t REG_TARGET_MOD = cfg_idx_t'(1);
  localparam cfg_idx_t REG_PRIME_ZERO = cfg_idx_t'(2);
  localparam cfg_idx_t REG_PRIME_ONE = cfg_idx_t'(3);
  localparam cfg_idx_t REG_PRIME_TWO = cfg_idx_t'(4);
  localparam cfg_idx_t REG_INV_P0 = cfg_idx_t'(5);
  localparam cfg_idx_t REG_INV_P0P1 = cfg_idx_t'(6);

  localparam logic [1:0] NP_TWO = 2'd2;
  localparam logic [1:0] NP_THREE = 2'd3;

  localparam word_t WORD_ONE = word_t'(1);

  typedef struct packed {
    word_t i1;
    word_t r1m;
    word_t p0p;
    word_t i2;
    word_t r2m;
    word_t q0q2;
    word_t res1;
  } side_b_t;

  typedef struct packed {
    word_t d1;
    word_t a0p;
    word_t a0q2;
    word_t p0p1p;
    word_t i1;
    word_t p0p;
    word_t i2;
    word_t r2m;
    word_t q0q2;
    word_t res1;
  } x1_t;

  typedef struct packed {
    word_t a0p;
    word_t a0q2;
    word_t p0p1p;
    word_t p0p;
    word_t i2;
    word_t r2m;
    word_t q0q2;
    word_t res1;
  } side_c_t;

  typedef struct packed {
    word_t a0p;
    word_t a0q2;
    word_t p0p1p;
    word_t i2;
    word_t r2m;
    word_t res1;
  } side_e_t;

  typedef struct packed {
    word_t acc;
    word_t d2;
    word_t p0p1p;
    word_t i2;
    word_t res1;
  } x2_t;

  typedef struct packed {
    word_t acc;
    word_t p0p1p;
    word_t res1;
  } side_f_t;

  typedef struct packed {
    word_t acc;
    word_t res1;
  } side_h_t;

  // x, y below m
  function automatic word_t add_m(word_t x, word_t y, word_t m);
    logic [WORD_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[WORD_BITS-1:0];
  endfunction

  // x, y below m
  function automatic word_t sub_m(word_t x, word_t y, word_t m);
    word_t d;
    if (x >= y) d = x - y;
    else d = x + (m - y);
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/crt_reconstruct_mod_p.sv -----
// Garner CRT reconstruction of one coefficient from up to three prime residues,
// reduced modulo target_modulus. Transactions stream at one per cycle, with no gaps
// while each finished result is taken; the pipeline depth is set by eight
// chained modular multiply/reduce units that each retire two operand bits per
// stage. The whole pipeline holds while a finished result is not taken. Load
// registers only while the pipeline is empty; primes ascending, inverses as
// specified, residues below their primes.
`timescale 1ns / 1ps
`default_nettype none

module crt_reconstruct_mod_p import crtr_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_wen,
  input wire cfg_idx_t cfg_index,
  input wire word_t cfg_data,
  input wire logic in_valid,
  output logic in_ready,
  input wire word_t residue_zero,
  input wire word_t residue_one,
  input wire word_t residue_two,
  output logic out_valid,
  input wire logic out_ready,
  output word_t result_coeff
);

  logic [1:0] np_q;
  word_t tm_q;
  word_t q0_q;
  word_t q1_q;
  word_t q2_q;
  word_t inv1_q;
  word_t inv2_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      np_q <= 2'd1;
      tm_q <= word_t'(2);
      q0_q <= word_t'(2);
      q1_q <= word_t'(2);
      q2_q <= word_t'(2);
      inv1_q <= '0;
      inv2_q <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_NUM_PRIMES: np_q <= cfg_data[1:0];
        REG_TARGET_MOD: tm_q <= cfg_data;
        REG_PRIME_ZERO: q0_q <= cfg_data;
        REG_PRIME_ONE: q1_q <= cfg_data;
        REG_PRIME_TWO: q2_q <= cfg_data;
        REG_INV_P0: inv1_q <= cfg_data;
        REG_INV_P0P1: inv2_q <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [PIPE_DEPTH-1:0] vld_q;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // first level: reduce every input against its modulus
  word_t a0, i1, r1m, p0p, i2, r2m, q0q2, q1p, res1;

  crtr_modmul u_a0 (.clk, .en, .a(WORD_ONE), .b(residue_zero), .m(q0_q), .prod(a0));
  crtr_modmul u_i1 (.clk, .en, .a(WORD_ONE), .b(inv1_q), .m(q1_q), .prod(i1));
  crtr_modmul u_r1 (.clk, .en, .a(WORD_ONE), .b(residue_one), .m(q1_q), .prod(r1m));
  crtr_modmul u_p0p (.clk, .en, .a(WORD_ONE), .b(q0_q), .m(tm_q), .prod(p0p));
  crtr_modmul u_i2 (.clk, .en, .a(WORD_ONE), .b(inv2_q), .m(q2_q), .prod(i2));
  crtr_modmul u_r2 (.clk, .en, .a(WORD_ONE), .b(residue_two), .m(q2_q), .prod(r2m));
  crtr_modmul u_q0q2 (.clk, .en, .a(WORD_ONE), .b(q0_q), .m(q2_q), .prod(q0q2));
  crtr_modmul u_q1p (.clk, .en, .a(WORD_ONE), .b(q1_q), .m(tm_q), .prod(q1p));
  crtr_modmul u_res1 (.clk, .en, .a(WORD_ONE), .b(residue_zero), .m(tm_q), .prod(res1));

  side_b_t sb_in;
  side_b_t sb_q [MM_STAGES];

  assign sb_in = '{i1: i1, r1m: r1m, p0p: p0p, i2: i2, r2m: r2m, q0q2: q0q2, res1: res1};

  // second level
  word_t a0q1, a0p, a0q2, p0p1p;

  crtr_modmul u_a0q1 (.clk, .en, .a(WORD_ONE), .b(a0), .m(q1_q), .prod(a0q1));
  crtr_modmul u_a0p (.clk, .en, .a(WORD_ONE), .b(a0), .m(tm_q), .prod(a0p));
  crtr_modmul u_a0q2 (.clk, .en, .a(WORD_ONE), .b(a0), .m(q2_q), .prod(a0q2));
  crtr_modmul u_p0p1p (.clk, .en, .a(p0p), .b(q1p), .m(tm_q), .prod(p0p1p));

  x1_t x1_q;
  side_b_t sb_o;

  assign sb_o = sb_q[MM_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      x1_q.d1 <= sub_m(sb_o.r1m, a0q1, q1_q);
      x1_q.a0p <= a0p;
      x1_q.a0q2 <= a0q2;
      x1_q.p0p1p <= p0p1p;
      x1_q.i1 <= sb_o.i1;
      x1_q.p0p <= sb_o.p0p;
      x1_q.i2 <= sb_o.i2;
      x1_q.r2m <= sb_o.r2m;
      x1_q.q0q2 <= sb_o.q0q2;
      x1_q.res1 <= sb_o.res1;
    end
  end

  // second mixed-radix digit
  word_t a1;
  side_c_t sc_in;
  side_c_t sc_q [MM_STAGES];
  side_c_t sd_q [MM_STAGES];

  crtr_modmul u_a1 (.clk, .en, .a(x1_q.d1), .b(x1_q.i1), .m(q1_q), .prod(a1));

  assign sc_in = '{a0p: x1_q.a0p, a0q2: x1_q.a0q2, p0p1p: x1_q.p0p1p, p0p: x1_q.p0p,
                   i2: x1_q.i2, r2m: x1_q.r2m, q0q2: x1_q.q0q2, res1: x1_q.res1};

  word_t a1p, a1q2;

  crtr_modmul u_a1p (.clk, .en, .a(WORD_ONE), .b(a1), .m(tm_q), .prod(a1p));
  crtr_modmul u_a1q2 (.clk, .en, .a(WORD_ONE), .b(a1), .m(q2_q), .prod(a1q2));

  side_c_t sd_o;
  side_e_t se_in;
  side_e_t se_q [MM_STAGES];

  assign sd_o = sd_q[MM_STAGES-1];
  assign se_in = '{a0p: sd_o.a0p, a0q2: sd_o.a0q2, p0p1p: sd_o.p0p1p, i2: sd_o.i2,
                   r2m: sd_o.r2m, res1: sd_o.res1};

  word_t m1, m2;

  crtr_modmul u_m1 (.clk, .en, .a(a1p), .b(sd_o.p0p), .m(tm_q), .prod(m1));
  crtr_modmul u_m2 (.clk, .en, .a(a1q2), .b(sd_o.q0q2), .m(q2_q), .prod(m2));

  x2_t x2_q;
  side_e_t se_o;

  assign se_o = se_q[MM_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      x2_q.acc <= add_m(se_o.a0p, m1, tm_q);
      x2_q.d2 <= sub_m(se_o.r2m, add_m(se_o.a0q2, m2, q2_q), q2_q);
      x2_q.p0p1p <= se_o.p0p1p;
      x2_q.i2 <= se_o.i2;
      x2_q.res1 <= se_o.res1;
    end
  end

  // third mixed-radix digit
  word_t a2, a2p, m3;
  side_f_t sf_in;
  side_f_t sf_q [MM_STAGES];
  side_f_t sg_q [MM_STAGES];
  side_h_t sh_q [MM_STAGES];
  side_f_t sg_o;
  side_h_t sh_o;

  assign sf_in = '{acc: x2_q.acc, p0p1p: x2_q.p0p1p, res1: x2_q.res1};
  assign sg_o = sg_q[MM_STAGES-1];
  assign sh_o = sh_q[MM_STAGES-1];

  crtr_modmul u_a2 (.clk, .en, .a(x2_q.d2), .b(x2_q.i2), .m(q2_q), .prod(a2));
  crtr_modmul u_a2p (.clk, .en, .a(WORD_ONE), .b(a2), .m(tm_q), .prod(a2p));
  crtr_modmul u_m3 (.clk, .en, .a(a2p), .b(sg_o.p0p1p), .m(tm_q), .prod(m3));

  // side data delay lines, matched to the modular units
  always_ff @(posedge clk) begin
    if (en) begin
      sb_q[0] <= sb_in;
      sc_q[0] <= sc_in;
      sd_q[0] <= sc_q[MM_STAGES-1];
      se_q[0] <= se_in;
      sf_q[0] <= sf_in;
      sg_q[0] <= sf_q[MM_STAGES-1];
      sh_q[0] <= '{acc: sg_o.acc, res1: sg_o.res1};
      for (int k = 1; k < MM_STAGES; k++) begin
        sb_q[k] <= sb_q[k-1];
        sc_q[k] <= sc_q[k-1];
        sd_q[k] <= sd_q[k-1];
        se_q[k] <= se_q[k-1];
        sf_q[k] <= sf_q[k-1];
        sg_q[k] <= sg_q[k-1];
        sh_q[k] <= sh_q[k-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (np_q < NP_TWO) begin
        result_coeff <= sh_o.res1;
      end else if (np_q == NP_THREE) begin
        result_coeff <= add_m(sh_o.acc, m3, tm_q);
      end else begin
        result_coeff <= sh_o.acc;
      end
    end
  end

  a_x1_hold: assert property (@(posedge clk) disable iff (rst)
    !en && vld_q[2*MM_STAGES] |=> $stable(x1_q.d1) && vld_q[2*MM_STAGES])
    else $error("first digit stage moved during a stall");

  a_x2_hold: assert property (@(posedge clk) disable iff (rst)
    !en && vld_q[5*MM_STAGES+1] |=> $stable(x2_q.acc) && vld_q[5*MM_STAGES+1])
    else $error("partial sum stage moved during a stall");

  a_last_fill: assert property (@(posedge clk) disable iff (rst)
    en && vld_q[PIPE_DEPTH-2] |=> out_valid)
    else $error("transaction lost before the output register");

endmodule

`default_nettype wire

// ----- rtl/crtr_modmul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// a * b mod m, double-and-add from the top bit of b, MM_STEP bits a stage
// with a = 1 it reduces b modulo m
module crtr_modmul import crtr_pkg::*; (
  input wire logic clk,
  input wire logic en,
  input wire word_t a,
  input wire word_t b,
  input wire word_t m,
  output word_t prod
);

  word_t r_q [MM_STAGES];
  word_t a_q [MM_STAGES];
  logic [MM_PAD-1:0] b_q [MM_STAGES];

  for (genvar k = 0; k < MM_STAGES; k++) begin : g_stage
    word_t r_in;
    word_t a_in;
    word_t r_acc;
    logic [MM_PAD-1:0] b_in;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign a_in = a;
      assign b_in = MM_PAD'(b);
    end else begin : g_next
      assign r_in = r_q[k-1];
      assign a_in = a_q[k-1];
      assign b_in = b_q[k-1];
    end

    always_comb begin
      r_acc = r_in;
      for (int j = 0; j < MM_STEP; j++) begin
        r_acc = add_m(r_acc, r_acc, m);
        if (b_in[MM_PAD-1-j]) r_acc = add_m(r_acc, a_in, m);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[k] <= r_acc;
        a_q[k] <= a_in;
        b_q[k] <= b_in << MM_STEP;
      end
    end
  end

  // a zero modulus gives zero
  assign prod = (m == '0) ? '0 : r_q[MM_STAGES-1];

endmodule

`default_nettype wire
